// ----- sv/assert_macros.svh -----
// Assertion helpers used by indexed_card_list_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- sv/icl_pkg.sv -----
`timescale 1ns / 1ps

package icl_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Number of cells folded into one first-level select register.
  localparam int unsigned GroupSize = 32;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } icl_op_e;

  // Control state of the request sequencer.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } icl_state_e;

  // Input beat.
  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] position;
    logic [7:0] card_in;
  } icl_in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] card_out;
    logic       found;
    logic [6:0] list_length;
  } icl_out_t;

endpackage

// ----- sv/icl_cell.sv -----
`timescale 1ns / 1ps

module icl_cell
  import icl_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned PW        = 7,
  parameter int unsigned CARD_BITS = 8
) (
  input  logic                 clk_i,
  input  icl_op_e              op_i,
  input  logic [PW-1:0]        pos_i,
  input  logic [CARD_BITS-1:0] card_i,
  input  logic [CARD_BITS-1:0] left_i,
  input  logic [CARD_BITS-1:0] right_i,
  output logic [CARD_BITS-1:0] val_o,
  output logic [CARD_BITS-1:0] rd_o
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic [CARD_BITS-1:0] val_q, val_d;

  // Take the new card, shift from a neighbor, or hold.
  always_comb begin
    val_d = val_q;
    case (op_i)
      OP_INSERT: begin
        if (pos_i == MyIdx) begin
          val_d = card_i;
        end else if (MyIdx > pos_i) begin
          val_d = left_i;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_i) begin
          val_d = right_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // This cell's contribution to the read select; zero unless addressed.
  assign val_o = val_q;
  assign rd_o  = (pos_i == MyIdx) ? val_q : '0;

endmodule

// ----- sv/icl_or_group.sv -----
`timescale 1ns / 1ps

module icl_or_group #(
  parameter int unsigned N = 32,
  parameter int unsigned W = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [N-1:0][W-1:0] vals_i,
  output logic [W-1:0]        or_o
);

  logic [W-1:0] or_q, or_d;

  // At most one input is nonzero, so an OR selects it.
  always_comb begin
    or_d = '0;
    for (int unsigned i = 0; i < N; i++) begin
      or_d = or_d | vals_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      or_q <= or_d;
    end
  end

  assign or_o = or_q;

endmodule

// ----- sv/indexed_card_list_top.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Positional card list built as a chain of CAPACITY cells, one entry each; on an insert
// every cell above the position takes its lower neighbor and on a remove every cell at or
// above it takes its upper neighbor, all in the cycle of the accepting edge. Insert, remove
// and unused codes register their result beat at the accepting edge and can follow each
// other every cycle unless the output stalls; a read goes through a two-level select (a
// registered OR per group of 32 cells, then a combinational OR across groups); its beat
// is loaded from the group registers in ST_READ, where the input is not ready. One request
// is in flight at a time; a new one is taken while the previous result beat leaves in the
// same cycle. Invalid inserts and removes leave the list unchanged and return found low.
module indexed_card_list_top
  import icl_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned CARD_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  icl_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output icl_out_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;
  localparam int unsigned NG = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  icl_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;
  icl_out_t out_data_q, out_data_d;
  logic rd_hit_q, rd_hit_d;

  logic in_acc, out_acc, ins_ok, rem_ok, rd_ok, load_out;
  icl_op_e cell_op;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic [PW+6:0] pos_wide, cnt_wide;
  logic [CARD_BITS+7:0] card_wide, sel_wide;
  logic [CW+6:0] len_wide;
  logic [CARD_BITS-1:0] card;
  logic [CAPACITY-1:0][CARD_BITS-1:0] cell_val;
  logic [NG*GroupSize-1:0][CARD_BITS-1:0] rd_pad;
  logic [NG-1:0][CARD_BITS-1:0] grp_or;
  logic [CARD_BITS-1:0] sel_val;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;

  // Widen position and count to a common width, and fit the card to the cell width.
  assign pos_wide  = {{PW{1'b0}}, in_data_i.position};
  assign cnt_wide  = {{(PW + 7 - CW){1'b0}}, count_q};
  assign pos_ext   = pos_wide[PW-1:0];
  assign cnt_ext   = cnt_wide[PW-1:0];
  assign card_wide = {{CARD_BITS{1'b0}}, in_data_i.card_in};
  assign card      = card_wide[CARD_BITS-1:0];

  // Request decode.
  assign ins_ok = (in_data_i.req_type == REQ_INSERT) && (pos_ext <= cnt_ext) &&
                  (count_q != CapCount);
  assign rem_ok = (in_data_i.req_type == REQ_REMOVE) && (pos_ext < cnt_ext);
  assign rd_ok  = (in_data_i.req_type == REQ_READ) && (pos_ext < cnt_ext);

  always_comb begin
    cell_op = OP_HOLD;
    if (in_acc && ins_ok) begin
      cell_op = OP_INSERT;
    end else if (in_acc && rem_ok) begin
      cell_op = OP_REMOVE;
    end
  end

  // Chain of entry cells; the ends see their own value as the missing neighbor.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [CARD_BITS-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = cell_val[k];
    end else begin : g_mid_l
      assign left = cell_val[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = cell_val[k];
    end else begin : g_mid_r
      assign right = cell_val[k+1];
    end
    icl_cell #(
      .IDX       (k),
      .PW        (PW),
      .CARD_BITS (CARD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (pos_ext),
      .card_i  (card),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[k]),
      .rd_o    (rd_pad[k])
    );
  end

  for (genvar k = CAPACITY; k < NG * GroupSize; k++) begin : g_pad
    assign rd_pad[k] = '0;
  end

  // First select level: one registered OR per group of cells.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    icl_or_group #(
      .N (GroupSize),
      .W (CARD_BITS)
    ) u_grp (
      .clk_i  (clk_i),
      .en_i   (in_acc),
      .vals_i (rd_pad[g*GroupSize +: GroupSize]),
      .or_o   (grp_or[g])
    );
  end

  // Second select level across groups.
  always_comb begin
    sel_val = '0;
    for (int unsigned g = 0; g < NG; g++) begin
      sel_val = sel_val | grp_or[g];
    end
  end

  assign sel_wide = {8'b0, (rd_hit_q ? sel_val : {CARD_BITS{1'b0}})};

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (in_acc && ins_ok) begin
      count_d = count_q + CW'(1);
    end else if (in_acc && rem_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  assign len_wide = {7'b0, count_d};
  assign rd_hit_d = in_acc ? rd_ok : rd_hit_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.req_type == REQ_READ)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        load_out   = in_acc && (in_data_i.req_type != REQ_READ);
      end
      ST_READ: load_out = 1'b1;
      default: begin
        in_ready_o = 1'b0;
        load_out   = 1'b0;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d.list_length = len_wide[6:0];
      if (state_q == ST_READ) begin
        out_data_d.card_out = sel_wide[7:0];
        out_data_d.found    = rd_hit_q;
      end else begin
        out_data_d.card_out = 8'd0;
        out_data_d.found    = ins_ok || rem_ok;
      end
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    rd_hit_q   <= rd_hit_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the count and on the read sequencing.
  `ASSERT_NEVER(a_count_cap, clk_i, rst_ni, count_q > CapCount, "entry count above capacity")
  `ASSERT_PROP(a_ins_inc, clk_i, rst_ni, in_acc && ins_ok |=> count_q == $past(count_q) + CW'(1), "insert did not grow list")
  `ASSERT_PROP(a_rem_dec, clk_i, rst_ni, in_acc && rem_ok |=> count_q == $past(count_q) - CW'(1), "remove did not shrink list")
  `ASSERT_NEVER(a_read_slot, clk_i, rst_ni, (state_q == ST_READ) && out_valid_q, "read result has no free output slot")

endmodule

// ----- test/indexed_card_list_top_test.sv -----
`timescale 1ns / 1ps

module indexed_card_list_top_test;
  import icl_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  // The block defines no meaning for the fourth request code.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  icl_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  icl_out_t out_data_o;

  // Mirror of the list contents and length, updated as each request beat is taken.
  logic [7:0]  deck_cells [LIST_DEPTH];
  int unsigned deck_size = 0;

  icl_out_t    expected_replies [$];
  icl_out_t    head_reply;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  indexed_card_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Apply one request to the mirror and return the result beat it should produce.
  function automatic icl_out_t predict_list_request(icl_in_t req);
    icl_out_t reply;
    int       k;
    reply = '0;
    case (req.req_type)
      REQ_INSERT: begin
        if (req.position <= deck_size && deck_size < LIST_DEPTH) begin
          for (k = deck_size; k > req.position; k--) deck_cells[k] = deck_cells[k - 1];
          deck_cells[req.position] = req.card_in;
          deck_size++;
          reply.found = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (req.position < deck_size) begin
          for (k = req.position; k + 1 < deck_size; k++) deck_cells[k] = deck_cells[k + 1];
          deck_size--;
          reply.found = 1'b1;
        end
      end
      REQ_READ: begin
        if (req.position < deck_size) begin
          reply.card_out = deck_cells[req.position];
          reply.found = 1'b1;
        end
      end
      default: ;
    endcase
    reply.list_length = 7'(deck_size);
    return reply;
  endfunction

  function automatic icl_in_t make_request(logic [1:0] kind, int unsigned pos,
                                           int unsigned card);
    icl_in_t req;
    req.req_type = kind;
    req.position = 7'(pos);
    req.card_in = 8'(card);
    return req;
  endfunction

  // Draw a request with the given operation mix; most positions land inside the list.
  function automatic icl_in_t random_request(int unsigned ins_pct, int unsigned rem_pct,
                                             int unsigned read_pct);
    int unsigned roll;
    int unsigned pos;
    logic [1:0]  kind;
    roll = $urandom_range(99);
    if (roll < ins_pct) kind = REQ_INSERT;
    else if (roll < ins_pct + rem_pct) kind = REQ_REMOVE;
    else if (roll < ins_pct + rem_pct + read_pct) kind = REQ_READ;
    else kind = REQ_UNUSED;
    if ($urandom_range(9) == 0) pos = $urandom_range(LIST_DEPTH);
    else if (kind == REQ_INSERT) pos = $urandom_range(deck_size);
    else if (deck_size == 0) pos = 0;
    else pos = $urandom_range(deck_size - 1);
    return make_request(kind, pos, $urandom_range(255));
  endfunction

  // Send one request beat, with a random idle gap ahead of it, and record its result.
  task automatic send_request(input icl_in_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_replies.push_back(predict_list_request(req));
  endtask

  // Stop sending until every outstanding result beat has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_replies.size() != 0);
  endtask

  // Empty list, append, front and middle inserts, removes at both ends, misses.
  task automatic test_directed_edges();
    send_request(make_request(REQ_READ, 0, 0));
    send_request(make_request(REQ_REMOVE, 0, 0));
    send_request(make_request(REQ_INSERT, 1, 8'h11));
    send_request(make_request(REQ_UNUSED, 0, 8'hFF));
    send_request(make_request(REQ_INSERT, 0, 8'hFF));
    send_request(make_request(REQ_INSERT, 1, 8'h00));
    send_request(make_request(REQ_INSERT, 0, 8'hA5));
    send_request(make_request(REQ_INSERT, 1, 8'h5A));
    send_request(make_request(REQ_INSERT, 5, 8'h77));
    send_request(make_request(REQ_READ, 0, 0));
    send_request(make_request(REQ_READ, 3, 0));
    send_request(make_request(REQ_READ, 4, 0));
    send_request(make_request(REQ_READ, 64, 0));
    send_request(make_request(REQ_REMOVE, 4, 0));
    send_request(make_request(REQ_REMOVE, 3, 0));
    send_request(make_request(REQ_REMOVE, 0, 0));
    send_request(make_request(REQ_REMOVE, 64, 0));
    send_request(make_request(REQ_READ, 1, 0));
    send_request(make_request(REQ_UNUSED, 64, 8'h3C));
    send_request(make_request(REQ_REMOVE, 0, 0));
    send_request(make_request(REQ_REMOVE, 0, 0));
    send_request(make_request(REQ_READ, 0, 0));
  endtask

  // Push the list up to capacity with insert-heavy traffic, then shrink it to empty.
  task automatic test_fill_and_drain(input int unsigned fill_items,
                                     input int unsigned drain_items);
    repeat (fill_items) send_request(random_request(80, 5, 12));
    repeat (drain_items) send_request(random_request(10, 70, 17));
  endtask

  // Balanced traffic that keeps the list around the middle of its range.
  task automatic test_mixed_traffic(input int unsigned items);
    repeat (items) begin
      if (deck_size < LIST_DEPTH / 2) send_request(random_request(50, 25, 22));
      else send_request(random_request(25, 50, 22));
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result beat with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
      end else begin
        head_reply = expected_replies.pop_front();
        if (out_data_o.card_out !== head_reply.card_out) begin
          $error("card_out: expected %0d, actual %0d", head_reply.card_out,
                 out_data_o.card_out);
          error_count++;
        end
        if (out_data_o.found !== head_reply.found) begin
          $error("found: expected %0d, actual %0d", head_reply.found, out_data_o.found);
          error_count++;
        end
        if (out_data_o.list_length !== head_reply.list_length) begin
          $error("list_length: expected %0d, actual %0d", head_reply.list_length,
                 out_data_o.list_length);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 23;
    recv_idle_pct = 68;
    test_directed_edges();
    test_fill_and_drain(150, 150);
    wait_for_drain();

    send_idle_pct = 68;
    recv_idle_pct = 23;
    test_mixed_traffic(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_and_drain(150, 150);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
